// File: rtl/core/pcwh_pkg.sv
package pcwh_pkg;

    localparam int DATA_W         = 64;
    localparam int FUNC_W         = 2;
    localparam int BASE_W         = 48;
    localparam int BLOCK_W        = 25;
    localparam int LEN_W          = 46;
    localparam int INDEX_BITS     = 45;
    localparam int BLOCK_POS_BITS = 24;
    localparam int CFG_IDX_W      = 2;
    localparam int LANES          = 8;
    localparam int LANE_W         = 3;
    localparam int HALF_W         = DATA_W / 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;
    localparam int QCNT_W         = 2;

    // input func codes
    localparam logic [FUNC_W-1:0] FUNC_GEN     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    // classified operations handed from front to back
    typedef logic [1:0] op_t;
    localparam op_t OP_GEN     = 2'd0;
    localparam op_t OP_CHECK   = 2'd1;
    localparam op_t OP_RESTART = 2'd2;
    localparam op_t OP_NOP     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd3;

    localparam logic [DATA_W-1:0]  XS_MULT      = 64'h2545_F491_4F6C_DD1D;
    localparam logic [DATA_W-1:0]  FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
    // FNV prime is 2^40 + 0x1b3
    localparam int                 FNV_SHIFT    = 40;
    localparam logic [8:0]         FNV_PRIME_LO = 9'h1B3;
    localparam logic [BLOCK_W-1:0] BLOCK_RESET  = 25'd512;
    localparam logic [LEN_W-1:0]   LENGTH_RESET = 46'd512;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] read_word;
    } item_t;

    function automatic logic [DATA_W-1:0] xs_shift(input logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] v;
        v = s ^ (s >> 12);
        v = v ^ (v << 25);
        v = v ^ (v >> 27);
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] fnv_step(input logic [DATA_W-1:0] h,
                                                   input logic [7:0] b);
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] lo;
        x  = h ^ DATA_W'(b);
        lo = DATA_W'(x * DATA_W'(FNV_PRIME_LO));
        return (x << FNV_SHIFT) + lo;
    endfunction

endpackage

// File: rtl/core/pcwh_in_if.sv
interface pcwh_in_if;
    logic                          valid;
    logic                          ready;
    logic [pcwh_pkg::FUNC_W-1:0]   func;
    logic [pcwh_pkg::DATA_W-1:0]   read_word;

    modport source (output valid, output func, output read_word, input ready);
    modport sink   (input valid, input func, input read_word, output ready);
endinterface

// File: rtl/core/pcwh_out_if.sv
interface pcwh_out_if;
    logic                          valid;
    logic                          ready;
    logic [pcwh_pkg::DATA_W-1:0]   pattern_word;
    logic [pcwh_pkg::DATA_W-1:0]   gen_digest;
    logic [pcwh_pkg::DATA_W-1:0]   read_digest;
    logic                          mismatch_found;
    logic [pcwh_pkg::DATA_W-1:0]   fault_offset;
    logic                          region_end;

    modport source (output valid, output pattern_word, output gen_digest,
                    output read_digest, output mismatch_found, output fault_offset,
                    output region_end, input ready);
    modport sink   (input valid, input pattern_word, input gen_digest,
                    input read_digest, input mismatch_found, input fault_offset,
                    input region_end, output ready);
endinterface

// File: rtl/core/pcwh_front.sv
module pcwh_front
(
    input  logic                clk,
    input  logic                rst_n,
    pcwh_in_if.sink             in_ch,
    output logic                item_valid,
    output pcwh_pkg::item_t     item,
    input  logic                item_pop
);

    pcwh_pkg::item_t                  q_reg [pcwh_pkg::QUEUE_DEPTH];
    logic [pcwh_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [pcwh_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [pcwh_pkg::QCNT_W-1:0]      count_reg;
    logic [pcwh_pkg::QCNT_W-1:0]      count_next;
    logic                             push;
    pcwh_pkg::op_t                    op_dec;

    // classify func into an operation code
    always_comb
    begin
        case (in_ch.func)
            pcwh_pkg::FUNC_GEN:     op_dec = pcwh_pkg::OP_GEN;
            pcwh_pkg::FUNC_CHECK:   op_dec = pcwh_pkg::OP_CHECK;
            pcwh_pkg::FUNC_RESTART: op_dec = pcwh_pkg::OP_RESTART;
            default:                op_dec = pcwh_pkg::OP_NOP;
        endcase
    end

    assign in_ch.ready = (count_reg != pcwh_pkg::QCNT_W'(pcwh_pkg::QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign item_valid  = (count_reg != '0);
    assign item        = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !item_pop)
        begin
            count_next = count_reg + pcwh_pkg::QCNT_W'(1);
        end
        else if (!push && item_pop)
        begin
            count_next = count_reg - pcwh_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + pcwh_pkg::QPTR_W'(1);
            end
            if (item_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + pcwh_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].op        <= op_dec;
            q_reg[wr_ptr_reg].read_word <= in_ch.read_word;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pcwh_pkg::QCNT_W'(pcwh_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

// File: rtl/core/pcwh_back.sv
module pcwh_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  pcwh_pkg::item_t                     item,
    output logic                                item_pop,
    input  logic                                cfg_we,
    input  logic [pcwh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcwh_pkg::DATA_W-1:0]         cfg_wdata,
    pcwh_out_if.source                          out_ch
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL0 = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_HASH = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam int DW = pcwh_pkg::DATA_W;
    localparam int HW = pcwh_pkg::HALF_W;
    localparam int IB = pcwh_pkg::INDEX_BITS;
    localparam int PB = pcwh_pkg::BLOCK_POS_BITS;

    // configuration
    logic [DW-1:0]                       seed_cfg_reg;
    logic [pcwh_pkg::BASE_W-1:0]         base_reg;
    logic [pcwh_pkg::BLOCK_W-1:0]        blk_words_reg;
    logic [pcwh_pkg::LEN_W-1:0]          len_words_reg;

    // architectural state
    logic [DW-1:0]                       gen_seed_reg;
    logic [DW-1:0]                       chk_seed_reg;
    logic [DW-1:0]                       exp_hash_reg;
    logic [DW-1:0]                       act_hash_reg;
    logic [IB-1:0]                       gen_idx_reg;
    logic [IB-1:0]                       chk_idx_reg;
    logic [PB-1:0]                       blk_pos_reg;
    logic                                mm_flag_reg;
    logic                                frozen_reg;
    logic [DW-1:0]                       bad_off_reg;

    // sequencer
    logic [2:0]                          state_reg;
    logic [pcwh_pkg::LANE_W-1:0]         lane_cnt_reg;
    logic                                is_gen_reg;
    logic [DW-1:0]                       rd_reg;
    logic [DW-1:0]                       v_reg;
    logic [DW-1:0]                       prod_reg;
    logic [DW-1:0]                       hash_reg;

    // output slot
    logic                                out_valid_reg;
    logic [DW-1:0]                       o_pattern_reg;
    logic [DW-1:0]                       o_exp_reg;
    logic [DW-1:0]                       o_act_reg;
    logic                                o_mm_reg;
    logic [DW-1:0]                       o_off_reg;
    logic                                o_end_reg;

    logic                                start;
    logic                                ignored;
    logic [DW-1:0]                       gen_v;
    logic [DW-1:0]                       chk_v;
    logic [DW-1:0]                       seed_eff;
    logic [DW-1:0]                       hash_word;
    logic [7:0]                          hash_byte;
    logic [DW-1:0]                       diff;
    logic [pcwh_pkg::LANE_W-1:0]         bad_lane;
    logic                                first_bad;
    logic                                mm_next;
    logic [DW-1:0]                       bad_off_next;
    logic [IB:0]                         gen_inc;
    logic [IB:0]                         chk_inc;
    logic [PB:0]                         pos_inc;
    logic                                gen_last;
    logic                                chk_last;
    logic                                blk_end;

    assign start    = (state_reg == ST_IDLE) && item_valid
                      && (!out_valid_reg || out_ch.ready);
    assign item_pop = start;
    assign ignored  = (item.op == pcwh_pkg::OP_NOP)
                      || ((item.op == pcwh_pkg::OP_CHECK) && frozen_reg);

    assign gen_v    = pcwh_pkg::xs_shift(gen_seed_reg);
    assign chk_v    = pcwh_pkg::xs_shift(chk_seed_reg);
    assign seed_eff = (seed_cfg_reg == '0) ? DW'(1) : seed_cfg_reg;

    // hash runs over the pattern on generate, over the read bytes on check
    assign hash_word = is_gen_reg ? prod_reg : rd_reg;
    assign hash_byte = hash_word[lane_cnt_reg*8 +: 8];

    // first differing lane, lowest first; lane 7 when lanes 0-6 agree
    assign diff = prod_reg ^ rd_reg;
    always_comb
    begin
        bad_lane = pcwh_pkg::LANE_W'(pcwh_pkg::LANES - 1);
        for (int i = pcwh_pkg::LANES - 2; i >= 0; i--)
        begin
            if (diff[i*8 +: 8] != 8'd0)
            begin
                bad_lane = pcwh_pkg::LANE_W'(i);
            end
        end
    end

    assign first_bad    = (diff != '0) && !mm_flag_reg;
    assign mm_next      = mm_flag_reg || (diff != '0);
    assign bad_off_next = first_bad ? (DW'(base_reg) + DW'({chk_idx_reg, bad_lane}))
                                    : bad_off_reg;

    assign gen_inc  = (IB+1)'(gen_idx_reg) + (IB+1)'(1);
    assign chk_inc  = (IB+1)'(chk_idx_reg) + (IB+1)'(1);
    assign pos_inc  = (PB+1)'(blk_pos_reg) + (PB+1)'(1);
    assign gen_last = (DW'(gen_inc) == DW'(len_words_reg));
    assign chk_last = (DW'(chk_inc) == DW'(len_words_reg));
    assign blk_end  = chk_last || (DW'(pos_inc) == DW'(blk_words_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_cfg_reg  <= DW'(1);
            base_reg      <= '0;
            blk_words_reg <= pcwh_pkg::BLOCK_RESET;
            len_words_reg <= pcwh_pkg::LENGTH_RESET;
            gen_seed_reg  <= DW'(1);
            chk_seed_reg  <= DW'(1);
            exp_hash_reg  <= pcwh_pkg::FNV_BASIS;
            act_hash_reg  <= pcwh_pkg::FNV_BASIS;
            gen_idx_reg   <= '0;
            chk_idx_reg   <= '0;
            blk_pos_reg   <= '0;
            mm_flag_reg   <= 1'b0;
            frozen_reg    <= 1'b0;
            bad_off_reg   <= '1;
            state_reg     <= ST_IDLE;
            lane_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pcwh_pkg::CFG_SEED:   seed_cfg_reg  <= cfg_wdata;
                    pcwh_pkg::CFG_BASE:   base_reg      <= cfg_wdata[pcwh_pkg::BASE_W-1:0];
                    pcwh_pkg::CFG_BLOCK:  blk_words_reg <= cfg_wdata[pcwh_pkg::BLOCK_W-1:0];
                    pcwh_pkg::CFG_LENGTH: len_words_reg <= cfg_wdata[pcwh_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    lane_cnt_reg <= '0;
                    if (start)
                    begin
                        if (item.op == pcwh_pkg::OP_RESTART)
                        begin
                            gen_seed_reg  <= seed_eff;
                            chk_seed_reg  <= seed_eff;
                            exp_hash_reg  <= pcwh_pkg::FNV_BASIS;
                            act_hash_reg  <= pcwh_pkg::FNV_BASIS;
                            gen_idx_reg   <= '0;
                            chk_idx_reg   <= '0;
                            blk_pos_reg   <= '0;
                            mm_flag_reg   <= 1'b0;
                            frozen_reg    <= 1'b0;
                            bad_off_reg   <= '1;
                            out_valid_reg <= 1'b1;
                        end
                        else if (ignored)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                        else if (item.op == pcwh_pkg::OP_GEN)
                        begin
                            gen_seed_reg <= gen_v;
                            state_reg    <= ST_MUL0;
                        end
                        else
                        begin
                            chk_seed_reg <= chk_v;
                            state_reg    <= ST_MUL0;
                        end
                    end
                end
                ST_MUL0: state_reg <= ST_MUL1;
                ST_MUL1: state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_HASH;
                ST_HASH:
                begin
                    lane_cnt_reg <= lane_cnt_reg + pcwh_pkg::LANE_W'(1);
                    if (lane_cnt_reg == pcwh_pkg::LANE_W'(pcwh_pkg::LANES - 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    state_reg     <= ST_IDLE;
                    out_valid_reg <= 1'b1;
                    if (is_gen_reg)
                    begin
                        exp_hash_reg <= hash_reg;
                        gen_idx_reg  <= gen_last ? '0 : gen_inc[IB-1:0];
                    end
                    else
                    begin
                        act_hash_reg <= hash_reg;
                        mm_flag_reg  <= mm_next;
                        bad_off_reg  <= bad_off_next;
                        chk_idx_reg  <= chk_last ? '0 : chk_inc[IB-1:0];
                        blk_pos_reg  <= blk_end ? '0 : pos_inc[PB-1:0];
                        frozen_reg   <= frozen_reg || (blk_end && mm_next);
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    is_gen_reg <= (item.op == pcwh_pkg::OP_GEN);
                    rd_reg     <= item.read_word;
                    v_reg      <= (item.op == pcwh_pkg::OP_GEN) ? gen_v : chk_v;
                    hash_reg   <= (item.op == pcwh_pkg::OP_GEN) ? exp_hash_reg : act_hash_reg;
                    if (item.op == pcwh_pkg::OP_RESTART)
                    begin
                        o_pattern_reg <= '0;
                        o_exp_reg     <= pcwh_pkg::FNV_BASIS;
                        o_act_reg     <= pcwh_pkg::FNV_BASIS;
                        o_mm_reg      <= 1'b0;
                        o_off_reg     <= '1;
                        o_end_reg     <= 1'b0;
                    end
                    else if (ignored)
                    begin
                        o_pattern_reg <= '0;
                        o_exp_reg     <= exp_hash_reg;
                        o_act_reg     <= act_hash_reg;
                        o_mm_reg      <= mm_flag_reg;
                        o_off_reg     <= bad_off_reg;
                        o_end_reg     <= 1'b0;
                    end
                end
            end
            // low 64 bits of v * XS_MULT from three 32x32 partial products
            ST_MUL0:
            begin
                prod_reg <= DW'(v_reg[HW-1:0] * pcwh_pkg::XS_MULT[HW-1:0]);
            end
            ST_MUL1:
            begin
                prod_reg[DW-1:HW] <= prod_reg[DW-1:HW]
                                     + HW'(v_reg[HW-1:0] * pcwh_pkg::XS_MULT[DW-1:HW]);
            end
            ST_MUL2:
            begin
                prod_reg[DW-1:HW] <= prod_reg[DW-1:HW]
                                     + HW'(v_reg[DW-1:HW] * pcwh_pkg::XS_MULT[HW-1:0]);
            end
            ST_HASH:
            begin
                hash_reg <= pcwh_pkg::fnv_step(hash_reg, hash_byte);
            end
            ST_FIN:
            begin
                o_pattern_reg <= prod_reg;
                if (is_gen_reg)
                begin
                    o_exp_reg <= hash_reg;
                    o_act_reg <= act_hash_reg;
                    o_mm_reg  <= mm_flag_reg;
                    o_off_reg <= bad_off_reg;
                    o_end_reg <= gen_last;
                end
                else
                begin
                    o_exp_reg <= exp_hash_reg;
                    o_act_reg <= hash_reg;
                    o_mm_reg  <= mm_next;
                    o_off_reg <= bad_off_next;
                    o_end_reg <= chk_last;
                end
            end
            default: ;
        endcase
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.pattern_word   = o_pattern_reg;
    assign out_ch.gen_digest     = o_exp_reg;
    assign out_ch.read_digest    = o_act_reg;
    assign out_ch.mismatch_found = o_mm_reg;
    assign out_ch.fault_offset   = o_off_reg;
    assign out_ch.region_end     = o_end_reg;

    a_frozen_has_mm: assert property (@(posedge clk) disable iff (!rst_n)
        frozen_reg |-> mm_flag_reg)
        else $error("hash frozen without a recorded mismatch");

    a_slot_free_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> !out_valid_reg)
        else $error("result slot busy when item finishes");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished item not presented");

    a_frozen_hash_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(frozen_reg) && frozen_reg) |-> $stable(act_hash_reg))
        else $error("actual hash moved while frozen");

endmodule

// File: rtl/core/pattern_check_with_hash_unit.sv
// A generate or check transaction goes through dispatch, the three-step 32x32 pattern multiply,
//   the eight-byte FNV fold (one byte per cycle) and a finish state before its result is valid;
//   restart and ignored items have it valid in the cycle after acceptance. The back end takes
//   no new item until the current one has finished and the result slot is free or draining.
// Reset (rst_n, async low): registers at seed 1, base 0, block/length 512; generators at 1,
//   hashes at the offset basis, queue and result slot empty.
module pattern_check_with_hash_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    pcwh_in_if.sink                             in_ch,
    pcwh_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [pcwh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcwh_pkg::DATA_W-1:0]         cfg_wdata
);

    // front -> back handoff: head of a two-entry queue
    logic               item_valid;
    pcwh_pkg::item_t    item;
    logic               item_pop;

    // Front end: takes transactions while the queue has room, decodes func
    // into an operation code (unknown codes become a no-op).
    pcwh_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // Back end: owns the config registers, both xorshift64* generators, both
    // FNV-1a-64 hashes and the mismatch record. It pops the next item only
    // when the output register is free or draining, so a waiting result
    // never blocks the queue from filling.
    pcwh_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .out_ch     (out_ch)
    );

endmodule
